@@ rtl/core/tsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and codes for the transmit timestamp match ring.
// ----------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;

  // request codes
  localparam logic [1:0] FUNC_ISSUE    = 2'd0;
  localparam logic [1:0] FUNC_COMPLETE = 2'd1;
  localparam logic [1:0] FUNC_POP      = 2'd2;
  localparam logic [1:0] FUNC_PUSH     = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_ISSUED  = 3'd0;
  localparam logic [2:0] KIND_STAMPED = 3'd1;
  localparam logic [2:0] KIND_IGNORED = 3'd2;
  localparam logic [2:0] KIND_POPPED  = 3'd3;
  localparam logic [2:0] KIND_EMPTY   = 3'd4;
  localparam logic [2:0] KIND_FULL    = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] byte_count;
    logic [31:0] report_id;
    logic [31:0] stamp_sec;
    logic [29:0] stamp_nsec;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] entry_tag;
    logic [31:0] time_sec;
    logic [29:0] time_nsec;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic tag_en;
    logic time_en;
  } mem_wr_t;

  typedef struct packed {
    logic le;
    logic eq;
  } cmp_res_t;

endpackage

`default_nettype wire

@@ rtl/core/tsr_mem.sv @@
// ----------------------------------------------------------------------------
// tsr_mem
// Ring record storage: tag, seconds and nanoseconds, one write and one
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_mem #(
  parameter int QUEUE_DEPTH = tsr_pkg::QUEUE_DEPTH_DEF,
  parameter int SW          = $clog2(QUEUE_DEPTH)
) (
  input  wire logic            clk,
  input  wire tsr_pkg::mem_wr_t wr_en,
  input  wire logic [SW-1:0]   wr_addr,
  input  wire logic [31:0]     wr_tag,
  input  wire logic [31:0]     wr_sec,
  input  wire logic [29:0]     wr_nsec,
  input  wire logic [SW-1:0]   rd_addr,
  output logic [31:0]          rd_tag,
  output logic [31:0]          rd_sec,
  output logic [29:0]          rd_nsec
);

  logic [31:0] tag_mem  [QUEUE_DEPTH];
  logic [31:0] sec_mem  [QUEUE_DEPTH];
  logic [29:0] nsec_mem [QUEUE_DEPTH];

  logic [31:0] rd_tag_r;
  logic [31:0] rd_sec_r;
  logic [29:0] rd_nsec_r;

  always_ff @(posedge clk) begin
    if (wr_en.tag_en) begin
      tag_mem[wr_addr] <= wr_tag;
    end
    if (wr_en.time_en) begin
      sec_mem[wr_addr]  <= wr_sec;
      nsec_mem[wr_addr] <= wr_nsec;
    end
  end

  always_ff @(posedge clk) begin
    rd_tag_r  <= tag_mem[rd_addr];
    rd_sec_r  <= sec_mem[rd_addr];
    rd_nsec_r <= nsec_mem[rd_addr];
  end

  assign rd_tag  = rd_tag_r;
  assign rd_sec  = rd_sec_r;
  assign rd_nsec = rd_nsec_r;

endmodule

`default_nettype wire

@@ rtl/core/tsr_cmp.sv @@
// ----------------------------------------------------------------------------
// tsr_cmp
// Tag compare unit shared by every step of the completion walk.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_cmp (
  input  wire logic [31:0] tag,
  input  wire logic [31:0] bound,
  output tsr_pkg::cmp_res_t res
);

  always_comb begin
    res.le = (tag <= bound);
    res.eq = (tag == bound);
  end

endmodule

`default_nettype wire

@@ rtl/core/tx_timestamp_match_ring.sv @@
// ----------------------------------------------------------------------------
// tx_timestamp_match_ring
// Ring of pending transmit records: issue, completion walk, pop and push.
// ----------------------------------------------------------------------------
//   channel   ports                   handshake
//   request   start, busy, in_data    taken when start && !busy
//   result    out_valid, out_data     one-cycle strobe, no back-pressure
//
// Issue, push and an empty pop answer from the execute state, a pop that finds
// a record after one registered memory read. A completion with nothing pending
// is ignored from the execute state; otherwise the walk reads, compares and
// stamps one record a cycle through the shared tag compare unit; the final
// result is registered, via the flush state when the last record was stamped.
// Reset (rst_n low, synchronous) clears the pointers and the byte total;
// record storage needs no clearing. Results are never held off.
// ----------------------------------------------------------------------------
`default_nettype none

module tx_timestamp_match_ring #(
  parameter int QUEUE_DEPTH = tsr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire tsr_pkg::in_item_t in_data,
  output logic                   out_valid,
  output tsr_pkg::out_item_t     out_data
);

  localparam int SW   = $clog2(QUEUE_DEPTH);
  localparam int SPAN = 2 * QUEUE_DEPTH;
  localparam int PW   = $clog2(SPAN);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [PW-1:0]       issue_r, issue_nxt;
  logic [PW-1:0]       complete_r, complete_nxt;
  logic [PW-1:0]       consume_r, consume_nxt;
  logic [31:0]         total_r, total_nxt;
  tsr_pkg::in_item_t   req_r;
  logic [31:0]         bound_r;
  logic                first_r, first_nxt;
  logic [31:0]         hold_r, hold_nxt;
  logic                out_valid_r, out_valid_nxt;
  tsr_pkg::out_item_t  out_data_r, out_data_nxt;

  tsr_pkg::mem_wr_t    wr_en;
  logic [SW-1:0]       wr_addr;
  logic [31:0]         wr_tag;
  logic [SW-1:0]       rd_addr;
  logic [31:0]         rd_tag;
  logic [31:0]         rd_sec;
  logic [29:0]         rd_nsec;
  tsr_pkg::cmp_res_t   cmp;

  logic [PW-1:0]       issue_inc;
  logic [PW-1:0]       complete_inc;
  logic [PW-1:0]       consume_inc;
  logic                ring_full;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    n = (p == PW'(SPAN - 1)) ? '0 : p + PW'(1);
    return n;
  endfunction

  function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= PW'(QUEUE_DEPTH)) ? p - PW'(QUEUE_DEPTH) : p;
    return s[SW-1:0];
  endfunction

  function automatic tsr_pkg::out_item_t mk_res(input logic [2:0] kind,
                                                input logic [31:0] tag,
                                                input logic [31:0] sec,
                                                input logic [29:0] nsec,
                                                input logic last);
    tsr_pkg::out_item_t r;
    r.kind      = kind;
    r.entry_tag = tag;
    r.time_sec  = sec;
    r.time_nsec = nsec;
    r.last      = last;
    return r;
  endfunction

  tsr_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SW          (SW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_tag  (wr_tag),
    .wr_sec  (req_r.stamp_sec),
    .wr_nsec (req_r.stamp_nsec),
    .rd_addr (rd_addr),
    .rd_tag  (rd_tag),
    .rd_sec  (rd_sec),
    .rd_nsec (rd_nsec)
  );

  tsr_cmp u_cmp (
    .tag   (rd_tag),
    .bound (bound_r),
    .res   (cmp)
  );

  assign issue_inc    = next_ptr(issue_r);
  assign complete_inc = next_ptr(complete_r);
  assign consume_inc  = next_ptr(consume_r);

  // fill is issue - consume modulo the pointer span
  always_comb begin
    logic [PW:0] fill;
    if (issue_r >= consume_r) begin
      fill = {1'b0, issue_r} - {1'b0, consume_r};
    end else begin
      fill = {1'b0, issue_r} + (PW+1)'(SPAN) - {1'b0, consume_r};
    end
    ring_full = (fill >= (PW+1)'(QUEUE_DEPTH));
  end

  always_comb begin
    state_nxt     = state_r;
    issue_nxt     = issue_r;
    complete_nxt  = complete_r;
    consume_nxt   = consume_r;
    total_nxt     = total_r;
    first_nxt     = first_r;
    hold_nxt      = hold_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_en         = '0;
    wr_addr       = slot_of(issue_r);
    wr_tag        = total_r;
    rd_addr       = slot_of(complete_r);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        unique case (req_r.func)
          tsr_pkg::FUNC_ISSUE: begin
            if (ring_full) begin
              out_data_nxt = mk_res(tsr_pkg::KIND_FULL, '0, '0, '0, 1'b1);
            end else begin
              total_nxt    = total_r + req_r.byte_count;
              wr_en.tag_en = 1'b1;
              wr_tag       = total_nxt;
              issue_nxt    = issue_inc;
              out_data_nxt = mk_res(tsr_pkg::KIND_ISSUED, total_nxt, '0, '0, 1'b1);
            end
          end
          tsr_pkg::FUNC_COMPLETE: begin
            if (issue_r == complete_r) begin
              out_data_nxt = mk_res(tsr_pkg::KIND_IGNORED, '0, '0, '0, 1'b1);
            end else begin
              // oldest pending record is read now, compared next cycle
              out_valid_nxt = 1'b0;
              first_nxt     = 1'b1;
              state_nxt     = S_CMP;
            end
          end
          tsr_pkg::FUNC_POP: begin
            if (consume_r == complete_r) begin
              out_data_nxt = mk_res(tsr_pkg::KIND_EMPTY, '0, '0, '0, 1'b1);
            end else begin
              out_valid_nxt = 1'b0;
              rd_addr       = slot_of(consume_r);
              state_nxt     = S_POP;
            end
          end
          tsr_pkg::FUNC_PUSH: begin
            if (issue_r != complete_r) begin
              out_data_nxt = mk_res(tsr_pkg::KIND_IGNORED, '0, '0, '0, 1'b1);
            end else if (ring_full) begin
              out_data_nxt = mk_res(tsr_pkg::KIND_FULL, '0, '0, '0, 1'b1);
            end else begin
              wr_en.tag_en  = 1'b1;
              wr_en.time_en = 1'b1;
              issue_nxt     = issue_inc;
              complete_nxt  = issue_inc;
              out_data_nxt  = mk_res(tsr_pkg::KIND_STAMPED, total_r, req_r.stamp_sec,
                                     req_r.stamp_nsec, 1'b1);
            end
          end
        endcase
      end

      S_POP: begin
        state_nxt     = S_IDLE;
        consume_nxt   = consume_inc;
        out_valid_nxt = 1'b1;
        out_data_nxt  = mk_res(tsr_pkg::KIND_POPPED, rd_tag, rd_sec, rd_nsec, 1'b1);
      end

      S_CMP: begin
        if (!cmp.le) begin
          // walk stops: either a stale report or the previous stamp is the final one
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (first_r) begin
            out_data_nxt = mk_res(tsr_pkg::KIND_IGNORED, '0, '0, '0, 1'b1);
          end else begin
            out_data_nxt = mk_res(tsr_pkg::KIND_STAMPED, hold_r, req_r.stamp_sec,
                                  req_r.stamp_nsec, 1'b1);
          end
        end else begin
          wr_en.time_en = 1'b1;
          wr_addr       = slot_of(complete_r);
          complete_nxt  = complete_inc;
          hold_nxt      = rd_tag;
          first_nxt     = 1'b0;
          // previous stamp goes out once we know it is not the last
          if (!first_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = mk_res(tsr_pkg::KIND_STAMPED, hold_r, req_r.stamp_sec,
                                   req_r.stamp_nsec, 1'b0);
          end
          if (cmp.eq || (complete_inc == issue_r)) begin
            state_nxt = S_FLUSH;
          end else begin
            rd_addr = slot_of(complete_inc);
          end
        end
      end

      S_FLUSH: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_data_nxt  = mk_res(tsr_pkg::KIND_STAMPED, hold_r, req_r.stamp_sec,
                               req_r.stamp_nsec, 1'b1);
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= '0;
      complete_r  <= '0;
      consume_r   <= '0;
      total_r     <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      complete_r  <= complete_nxt;
      consume_r   <= consume_nxt;
      total_r     <= total_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request capture, bound wraps modulo 2^32 like the tags
  always_ff @(posedge clk) begin
    if (start && (state_r == S_IDLE)) begin
      req_r   <= in_data;
      bound_r <= in_data.report_id + 32'd1;
    end
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
